// File: design/pn_pkg.sv
`default_nettype none
package pn_pkg;

  localparam int PATH_MAX_DEF    = 256;
  localparam int MAX_PIECES_DEF  = 32;
  localparam int PIECE_LIMIT_DEF = 64;
  localparam int CHUNK_BYTES_DEF = 8;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic [9:0] CAP_RESET = 10'd256;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_JOIN    = 13'b0000000000010,
    S_BEGIN   = 13'b0000000000100,
    S_SCAN_RD = 13'b0000000001000,
    S_SCAN_PR = 13'b0000000010000,
    S_SUM_RD  = 13'b0000000100000,
    S_SUM_AC  = 13'b0000001000000,
    S_EM_PRD  = 13'b0000010000000,
    S_EM_PW   = 13'b0000100000000,
    S_EM_NEXT = 13'b0001000000000,
    S_EM_CW   = 13'b0010000000000,
    S_OUT     = 13'b0100000000000,
    S_ERR     = 13'b1000000000000
  } state_t;

endpackage
`default_nettype wire

// File: design/path_normalizer.sv
`default_nettype none
// Path normaliser. Working-directory characters and then path characters
// arrive one request per cycle while the block is idle and are written into
// an internal text memory; a path character that begins a relative join is
// written in a separate join state after the joining slash. The request
// flagged by tlast starts normalisation: the text memory is scanned one stored
// character at a time to build the piece table, the piece table is summed one
// piece at a time, and the result is then rebuilt from both memories and
// leaves as chunks of up to CHUNK_BYTES characters, each held until the
// receiver is ready. An error gives a single chunk with the error flag.
// No input is taken while a request is being normalised and emitted.
module path_normalizer #(
  parameter int PATH_MAX    = pn_pkg::PATH_MAX_DEF,
  parameter int MAX_PIECES  = pn_pkg::MAX_PIECES_DEF,
  parameter int PIECE_LIMIT = pn_pkg::PIECE_LIMIT_DEF,
  parameter int CHUNK_BYTES = pn_pkg::CHUNK_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [9:0]  cfg_wdata,       // out_capacity
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,        // char_byte
  input  wire  [1:0]  in_tuser,        // from_path, has_byte
  input  wire         in_tlast,        // end_of_request
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,       // chunk_bytes[63:0], chunk_count[67:64], zero pad
  output logic        out_tuser,       // error
  output logic        out_tlast        // final_chunk
);

  localparam int AW  = $clog2(PATH_MAX);
  localparam int NW  = $clog2(PIECE_LIMIT);
  localparam int CW  = $clog2(MAX_PIECES + 1);
  localparam int PIW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int TW  = $clog2(MAX_PIECES * PIECE_LIMIT + 2) + 1;

  pn_pkg::state_t state_r, state_nxt;

  logic [9:0]    cap_r;
  logic [AW-1:0] wlen_r, wlen_nxt;
  logic [7:0]    last_r, last_nxt;
  logic          started_r, started_nxt;
  logic          jerr_r, jerr_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          end_r, end_nxt;

  logic [AW-1:0] p_r, p_nxt;
  logic          inp_r, inp_nxt;
  logic [AW-1:0] st_r, st_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          d0_r, d0_nxt, d1_r, d1_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [TW-1:0] sum_r, sum_nxt, emit_r, emit_nxt;
  logic [AW-1:0] ps_r, ps_nxt;
  logic [NW-1:0] pn_r, pn_nxt, j_r, j_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          final_r, final_nxt;

  // Text memory and piece table.
  logic [7:0]       wb_mem [PATH_MAX];
  logic             wb_we;
  logic [AW-1:0]    wb_wa, wb_ra;
  logic [7:0]       wb_wd, wb_rd_r;
  logic [AW+NW-1:0] pm_mem [MAX_PIECES];
  logic             pm_we;
  logic [PIW-1:0]   pm_wa, pm_ra;
  logic [AW+NW-1:0] pm_wd, pm_rd_r;

  always_ff @(posedge clk) begin
    if (wb_we) begin
      wb_mem[wb_wa] <= wb_wd;
    end
    wb_rd_r <= wb_mem[wb_ra];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_wa] <= pm_wd;
    end
    pm_rd_r <= pm_mem[pm_ra];
  end

  logic [7:0] c_in;
  logic       fp_in, valid_c, accept;
  assign c_in    = in_tdata;
  assign fp_in   = in_tuser[0];
  assign valid_c = in_tuser[1] && (in_tdata != 8'd0);
  assign accept  = in_tvalid && in_tready;
  assign in_tready = (state_r == pn_pkg::S_IDLE) && rst_n;

  logic room;
  assign room = (32'(wlen_r) + 1 < PATH_MAX);

  logic [7:0] ch;
  logic       slash, fin, start_new;
  assign ch    = wb_rd_r;
  assign slash = (ch == pn_pkg::CH_SLASH);

  always_comb begin
    state_nxt   = state_r;
    wlen_nxt    = wlen_r;
    last_nxt    = last_r;
    started_nxt = started_r;
    jerr_nxt    = jerr_r;
    pend_nxt    = pend_r;
    end_nxt     = end_r;
    p_nxt       = p_r;
    inp_nxt     = inp_r;
    st_nxt      = st_r;
    n_nxt       = n_r;
    d0_nxt      = d0_r;
    d1_nxt      = d1_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    sum_nxt     = sum_r;
    emit_nxt    = emit_r;
    ps_nxt      = ps_r;
    pn_nxt      = pn_r;
    j_nxt       = j_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    final_nxt   = final_r;
    wb_we       = 1'b0;
    wb_wa       = wlen_r;
    wb_wd       = c_in;
    wb_ra       = p_r;
    pm_we       = 1'b0;
    pm_wa       = count_r[PIW-1:0];
    pm_wd       = {st_r, n_r};
    pm_ra       = i_r[PIW-1:0];
    fin         = 1'b0;
    start_new   = 1'b0;

    case (state_r)
      pn_pkg::S_IDLE: begin
        if (accept) begin
          end_nxt = in_tlast;
          pend_nxt = c_in;
          state_nxt = in_tlast ? pn_pkg::S_BEGIN : pn_pkg::S_IDLE;
          if (valid_c) begin
            if (!fp_in || started_r) begin
              if ((fp_in || !started_r) && room) begin
                wb_we = 1'b1;
                wlen_nxt = wlen_r + 1'b1;
                last_nxt = c_in;
              end
            end else begin
              started_nxt = 1'b1;
              if (c_in == pn_pkg::CH_SLASH) begin
                wb_we = 1'b1;
                wb_wa = '0;
                wlen_nxt = AW'(1);
                last_nxt = c_in;
              end else if (wlen_r == '0) begin
                wb_we = 1'b1;
                wb_wa = '0;
                wb_wd = pn_pkg::CH_SLASH;
                wlen_nxt = AW'(1);
                last_nxt = pn_pkg::CH_SLASH;
                state_nxt = pn_pkg::S_JOIN;
              end else if (last_r != pn_pkg::CH_SLASH) begin
                if (!room) begin
                  jerr_nxt = 1'b1;
                end else begin
                  wb_we = 1'b1;
                  wb_wd = pn_pkg::CH_SLASH;
                  wlen_nxt = wlen_r + 1'b1;
                  last_nxt = pn_pkg::CH_SLASH;
                  state_nxt = pn_pkg::S_JOIN;
                end
              end else if (room) begin
                wb_we = 1'b1;
                wlen_nxt = wlen_r + 1'b1;
                last_nxt = c_in;
              end
            end
          end
        end
      end

      pn_pkg::S_JOIN: begin
        wb_wd = pend_r;
        if (room) begin
          wb_we = 1'b1;
          wlen_nxt = wlen_r + 1'b1;
          last_nxt = pend_r;
        end
        state_nxt = end_r ? pn_pkg::S_BEGIN : pn_pkg::S_IDLE;
      end

      pn_pkg::S_BEGIN: begin
        wb_wd = pn_pkg::CH_SLASH;
        if (!started_r) begin
          if (wlen_r == '0) begin
            wb_we = 1'b1;
            wb_wa = '0;
            wlen_nxt = AW'(1);
          end else if (last_r != pn_pkg::CH_SLASH) begin
            if (!room) begin
              jerr_nxt = 1'b1;
            end else begin
              wb_we = 1'b1;
              wlen_nxt = wlen_r + 1'b1;
            end
          end
        end
        p_nxt = '0;
        inp_nxt = 1'b0;
        count_nxt = '0;
        state_nxt = pn_pkg::S_SCAN_RD;
      end

      pn_pkg::S_SCAN_RD: begin
        if (jerr_r || cap_r < 10'd2) begin
          state_nxt = pn_pkg::S_ERR;
        end else if (p_r == wlen_r) begin
          fin = inp_r;
          i_nxt = '0;
          sum_nxt = '0;
          state_nxt = pn_pkg::S_SUM_RD;
        end else begin
          state_nxt = pn_pkg::S_SCAN_PR;
        end
      end

      pn_pkg::S_SCAN_PR: begin
        p_nxt = p_r + 1'b1;
        state_nxt = pn_pkg::S_SCAN_RD;
        if (!inp_r) begin
          start_new = !slash;
        end else if (slash || 32'(n_r) == PIECE_LIMIT - 1) begin
          fin = 1'b1;
          start_new = !slash;
          inp_nxt = !slash;
        end else begin
          n_nxt = n_r + 1'b1;
          if (32'(n_r) == 1) begin
            d1_nxt = (ch == pn_pkg::CH_DOT);
          end
        end
      end

      pn_pkg::S_SUM_RD: begin
        if (i_r == count_r) begin
          i_nxt = '0;
          emit_nxt = '0;
          acc_nxt = '0;
          cnt_nxt = '0;
          if (count_r == '0) begin
            sum_nxt = TW'(1);
            state_nxt = pn_pkg::S_EM_PRD;
          end else if (32'(sum_r) >= 32'(cap_r)) begin
            state_nxt = pn_pkg::S_ERR;
          end else begin
            state_nxt = pn_pkg::S_EM_PRD;
          end
        end else begin
          state_nxt = pn_pkg::S_SUM_AC;
        end
      end

      pn_pkg::S_SUM_AC: begin
        sum_nxt = sum_r + TW'(pm_rd_r[NW-1:0]) + 1'b1;
        i_nxt = i_r + 1'b1;
        state_nxt = pn_pkg::S_SUM_RD;
      end

      pn_pkg::S_EM_PRD: begin
        state_nxt = (count_r == '0) ? pn_pkg::S_EM_CW : pn_pkg::S_EM_PW;
      end

      pn_pkg::S_EM_PW: begin
        ps_nxt = pm_rd_r[AW+NW-1:NW];
        pn_nxt = pm_rd_r[NW-1:0];
        j_nxt = '0;
      end

      pn_pkg::S_EM_NEXT: begin
        wb_ra = AW'(32'(ps_r) + 32'(j_r));
        if (j_r < pn_r) begin
          state_nxt = pn_pkg::S_EM_CW;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = pn_pkg::S_EM_PRD;
        end
      end

      pn_pkg::S_EM_CW: begin
        j_nxt = j_r + 1'b1;
      end

      pn_pkg::S_OUT: begin
        if (out_tready) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          state_nxt = final_r ? pn_pkg::S_IDLE : pn_pkg::S_EM_NEXT;
        end
      end

      pn_pkg::S_ERR: begin
        if (out_tready) begin
          state_nxt = pn_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pn_pkg::S_IDLE;
      end
    endcase

    // A byte goes into the chunk: the slash before a piece, the lone slash of
    // an empty result, or a character of a piece.
    if (state_r == pn_pkg::S_EM_PW || state_r == pn_pkg::S_EM_CW) begin
      acc_nxt[8*cnt_r[2:0] +: 8] = (state_r == pn_pkg::S_EM_PW || count_r == '0) ?
                                   pn_pkg::CH_SLASH : wb_rd_r;
      cnt_nxt = cnt_r + 1'b1;
      emit_nxt = emit_r + 1'b1;
      final_nxt = (emit_r + 1'b1 == sum_r);
      if (32'(cnt_r) + 1 == CHUNK_BYTES || emit_r + 1'b1 == sum_r) begin
        state_nxt = pn_pkg::S_OUT;
      end else begin
        state_nxt = pn_pkg::S_EM_NEXT;
      end
    end

    // Close the current piece: a lone dot is dropped, a double dot removes
    // the last kept piece, anything else is appended to the table, or gives an error if the table is full.
    if (fin) begin
      if (32'(n_r) == 1 && d0_r) begin
        count_nxt = count_r;
      end else if (32'(n_r) == 2 && d0_r && d1_r) begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
      end else if (32'(count_r) >= MAX_PIECES) begin
        state_nxt = pn_pkg::S_ERR;
      end else begin
        pm_we = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      if (!start_new) begin
        inp_nxt = 1'b0;
      end
    end

    if (start_new && state_nxt != pn_pkg::S_ERR) begin
      inp_nxt = 1'b1;
      st_nxt = p_r;
      n_nxt = NW'(1);
      d0_nxt = (ch == pn_pkg::CH_DOT);
      d1_nxt = 1'b0;
    end

    // Request state is cleared once the last chunk has been taken.
    if ((state_r == pn_pkg::S_ERR || (state_r == pn_pkg::S_OUT && final_r)) && out_tready) begin
      wlen_nxt = '0;
      started_nxt = 1'b0;
      jerr_nxt = 1'b0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pn_pkg::S_IDLE;
      cap_r     <= pn_pkg::CAP_RESET;
      wlen_r    <= '0;
      started_r <= 1'b0;
      jerr_r    <= 1'b0;
      count_r   <= '0;
      end_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      wlen_r    <= wlen_nxt;
      started_r <= started_nxt;
      jerr_r    <= jerr_nxt;
      count_r   <= count_nxt;
      end_r     <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    pend_r  <= pend_nxt;
    p_r     <= p_nxt;
    inp_r   <= inp_nxt;
    st_r    <= st_nxt;
    n_r     <= n_nxt;
    d0_r    <= d0_nxt;
    d1_r    <= d1_nxt;
    i_r     <= i_nxt;
    sum_r   <= sum_nxt;
    emit_r  <= emit_nxt;
    ps_r    <= ps_nxt;
    pn_r    <= pn_nxt;
    j_r     <= j_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    final_r <= final_nxt;
  end

  logic is_err;
  assign is_err     = (state_r == pn_pkg::S_ERR);
  assign out_tvalid = (state_r == pn_pkg::S_OUT) || is_err;
  assign out_tdata  = is_err ? 72'd0 : {4'd0, cnt_r, acc_r};
  assign out_tuser  = is_err;
  assign out_tlast  = is_err || final_r;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
module tb_top;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [7:0] CH_A = 8'h61;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  count;
    logic        err;
    logic        fin;
  } chunk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  path_normalizer DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model of the block's request state.
  logic [9:0] capacity = pn_pkg::CAP_RESET;
  logic [7:0] joined [pn_pkg::PATH_MAX_DEF];
  int         joined_len = 0;
  bit         path_begun = 0;
  bit         join_failed = 0;
  chunk_t     pending_chunks [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  send_idling = 0;
  bit  recv_idling = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic void store_char(input logic [7:0] c);
    if (joined_len + 1 < pn_pkg::PATH_MAX_DEF) begin
      joined[joined_len] = c;
      joined_len++;
    end
  endfunction

  function automatic void open_path(input bit absolute);
    path_begun = 1;
    if (absolute) begin
      joined_len = 0;
    end else if (joined_len == 0) begin
      joined[0] = pn_pkg::CH_SLASH;
      joined_len = 1;
    end else if (joined[joined_len-1] != pn_pkg::CH_SLASH) begin
      if (joined_len + 1 >= pn_pkg::PATH_MAX_DEF) join_failed = 1;
      else store_char(pn_pkg::CH_SLASH);
    end
  endfunction

  function automatic void push_error_chunk();
    chunk_t e;
    e = '{chars: '0, count: '0, err: 1'b1, fin: 1'b1};
    pending_chunks.push_back(e);
  endfunction

  function automatic void normalise_request();
    int p, st, n, pc, k, j, nres;
    int pstart [pn_pkg::MAX_PIECES_DEF];
    int plen [pn_pkg::MAX_PIECES_DEF];
    logic [7:0] txt [$];
    bit bad;
    chunk_t ch;
    p = 0; pc = 0; bad = 0;
    while (p < joined_len && !bad) begin
      while (p < joined_len && joined[p] == pn_pkg::CH_SLASH) p++;
      if (p >= joined_len) break;
      st = p; n = 0;
      while (p < joined_len && joined[p] != pn_pkg::CH_SLASH &&
             n < pn_pkg::PIECE_LIMIT_DEF - 1) begin
        n++; p++;
      end
      if (n == 1 && joined[st] == pn_pkg::CH_DOT) continue;
      if (n == 2 && joined[st] == pn_pkg::CH_DOT && joined[st+1] == pn_pkg::CH_DOT) begin
        if (pc > 0) pc--;
        continue;
      end
      if (pc >= pn_pkg::MAX_PIECES_DEF) bad = 1;
      else begin
        pstart[pc] = st; plen[pc] = n; pc++;
      end
    end
    if (join_failed || capacity < 2 || bad) begin
      push_error_chunk();
      return;
    end
    if (pc == 0) txt.push_back(pn_pkg::CH_SLASH);
    for (k = 0; k < pc; k++) begin
      if (txt.size() + 1 >= capacity) begin push_error_chunk(); return; end
      txt.push_back(pn_pkg::CH_SLASH);
      for (j = 0; j < plen[k]; j++) begin
        if (txt.size() + 1 >= capacity) begin push_error_chunk(); return; end
        txt.push_back(joined[pstart[k] + j]);
      end
    end
    nres = (txt.size() + pn_pkg::CHUNK_BYTES_DEF - 1) / pn_pkg::CHUNK_BYTES_DEF;
    for (k = 0; k < nres; k++) begin
      ch = '0;
      for (j = 0; j < pn_pkg::CHUNK_BYTES_DEF &&
           k*pn_pkg::CHUNK_BYTES_DEF + j < txt.size(); j++) begin
        ch.chars[8*j +: 8] = txt[k*pn_pkg::CHUNK_BYTES_DEF + j];
        ch.count++;
      end
      ch.fin = (k + 1 == nres);
      pending_chunks.push_back(ch);
    end
  endfunction

  function automatic void predict_item(input logic [7:0] c, input bit fp,
                                       input bit hb, input bit last);
    if (hb && c != 0) begin
      if (!fp) begin
        if (!path_begun) store_char(c);
      end else begin
        if (!path_begun) open_path(c == pn_pkg::CH_SLASH);
        store_char(c);
      end
    end
    if (last) begin
      if (!path_begun) open_path(0);
      normalise_request();
      joined_len = 0; path_begun = 0; join_failed = 0;
    end
  endfunction

  task automatic send_item(input logic [7:0] c, input bit fp, input bit hb,
                           input bit last);
    while (send_idling && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= {hb, fp};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(c, fp, hb, last);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    @(posedge clk);
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [9:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity = v;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return pn_pkg::CH_SLASH;
    if (r < 55) return pn_pkg::CH_DOT;
    if (r < 90) return 8'(CH_A + $urandom_range(25));
    return 8'($urandom_range(255, 1));
  endfunction

  // One request: working directory, then path, with optional noise items
  // (zero characters, empty markers and late working-directory characters).
  task automatic send_request(input logic [7:0] cwd [$], input logic [7:0] pth [$],
                              input bit noisy);
    int i, mode;
    foreach (cwd[k]) begin
      if (noisy && $urandom_range(9) == 0) send_item(8'h00, 1'($urandom_range(1)), 1, 0);
      send_item(cwd[k], 0, 1, 0);
    end
    for (i = 0; i < pth.size(); i++) begin
      if (noisy && $urandom_range(9) == 0) send_item(pick_char(), 0, 1, 0);
      if (noisy && $urandom_range(9) == 0)
        send_item(8'($urandom), 1'($urandom_range(1)), 0, 0);
      send_item(pth[i], 1, 1, i == pth.size() - 1);
    end
    if (pth.size() == 0) begin
      mode = $urandom_range(2);
      if (mode == 0) send_item(pick_char(), 0, 1, 1);
      else if (mode == 1) send_item(8'($urandom), 1'($urandom_range(1)), 0, 1);
      else send_item(8'h00, 1, 1, 1);
    end
  endtask

  task automatic send_text(input string cwd_s, input string path_s);
    logic [7:0] a [$];
    logic [7:0] b [$];
    foreach (cwd_s[i]) a.push_back(cwd_s[i]);
    foreach (path_s[i]) b.push_back(path_s[i]);
    send_request(a, b, 0);
  endtask

  task automatic send_repeat(input logic [7:0] c, input int n, input string tail);
    logic [7:0] a [$];
    logic [7:0] b [$];
    repeat (n) a.push_back(c);
    foreach (tail[i]) b.push_back(tail[i]);
    send_request(a, b, 0);
  endtask

  task automatic test_directed();
    send_text("", "");
    send_text("/usr/lib", "../bin/./x");
    send_text("/home/u", "/etc//passwd/");
    send_text("", "a/b");
    send_text("/a/", "..");
    send_text("x", "");
    send_item(8'hff, 0, 1, 0);
    send_item(8'h80, 1, 1, 0);
    send_item(8'h2f, 0, 1, 0);
    send_item(8'h01, 1, 1, 1);
    send_item(8'h00, 0, 0, 0);
    send_item(8'h62, 0, 1, 1);
  endtask

  task automatic test_limits();
    logic [7:0] a [$];
    logic [7:0] b [$];
    // A piece of 64 characters is cut into two pieces.
    send_repeat(CH_A, 64, "b");
    send_repeat(pn_pkg::CH_SLASH, 4, "..");
    // More kept pieces than the table holds.
    for (int i = 0; i < 33; i++) begin a.push_back(CH_A); a.push_back(pn_pkg::CH_SLASH); end
    b.push_back(CH_A);
    send_request(a, b, 0);
  endtask

  task automatic test_capacity();
    write_capacity(10'd0);   send_text("/", "a");
    write_capacity(10'd1);   send_text("", "");
    write_capacity(10'd2);   send_text("", ""); send_text("", "b");
    write_capacity(10'd3);   send_text("", "b"); send_text("", "bc");
    write_capacity(10'd10);  send_text("/abcd", "efgh"); send_text("/abcd", "efg");
    write_capacity(10'd1023); send_text("/x/y", "z");
    write_capacity(10'd512);
  endtask

  task automatic random_requests(input int target);
    logic [7:0] a [$];
    logic [7:0] b [$];
    while (items_sent < target) begin
      a.delete(); b.delete();
      repeat ($urandom_range(8)) a.push_back(pick_char());
      repeat ($urandom_range(12)) b.push_back(pick_char());
      if ($urandom_range(3) == 0 && b.size() > 0) b[0] = pn_pkg::CH_SLASH;
      send_request(a, b, $urandom_range(3) == 0);
      if ($urandom_range(15) == 0)
        write_capacity(10'($urandom_range(3) == 0 ? $urandom_range(20) :
                                                    $urandom_range(1023)));
    end
  endtask

  task automatic test_random();
    send_idling = 0; recv_idling = 0;
    random_requests(items_sent + 60);
    send_idling = 1; recv_idling = 1;
    random_requests(items_sent + 80);
  endtask

  task automatic test_drain_pause();
    send_item(pn_pkg::CH_SLASH, 0, 1, 0);
    send_item(CH_A, 0, 1, 1);
    send_item(CH_A, 0, 1, 0);
    // The sender holds off until the block has emitted everything owed.
    wait_drained();
    send_item(pn_pkg::CH_DOT, 1, 1, 0);
    send_item(CH_A, 1, 1, 1);
  endtask

  // Receiver and result checker.
  always @(posedge clk) begin
    chunk_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chunks.size() == 0) begin
        report_mismatch("unexpected chunk", out_tdata[63:0], 64'h0);
      end else begin
        want = pending_chunks.pop_front();
        if (out_tdata[63:0] != want.chars)
          report_mismatch("chunk_bytes", out_tdata[63:0], want.chars);
        if (out_tdata[67:64] != want.count)
          report_mismatch("chunk_count", 64'(out_tdata[67:64]), 64'(want.count));
        if (out_tdata[71:68] != 4'h0)
          report_mismatch("tdata padding", 64'(out_tdata[71:68]), 64'h0);
        if (out_tuser != want.err)
          report_mismatch("error", 64'(out_tuser), 64'(want.err));
        if (out_tlast != want.fin)
          report_mismatch("final_chunk", 64'(out_tlast), 64'(want.fin));
      end
    end
    out_tready <= recv_idling ? ($urandom_range(99) >= 16) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_capacity();
    test_drain_pause();
    test_random();
    write_capacity(pn_pkg::CAP_RESET);
    send_text("/p", "q");
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_chunks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
